// ===== rtl/core/grc_pkg.sv =====
// grc_pkg: shared constants, control word types and the microcode ROM for
// the graph reachability check. No dependencies; used by the top level and
// for parameter defaults.
package grc_pkg;

  localparam int NODES_DEFAULT = 64;
  localparam int NODE_W        = 6;
  localparam int COUNT_W       = 7;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  localparam int PC_W = 4;

  // read address select
  typedef enum logic [1:0] {
    RD_SCAN = 2'd0,
    RD_FROM = 2'd1,
    RD_TO   = 2'd2
  } rd_sel_t;

  // write select
  typedef enum logic [1:0] {
    WR_NONE    = 2'd0,
    WR_FROM_OR = 2'd1,
    WR_TO_OR   = 2'd2,
    WR_CLEAR   = 2'd3
  } wr_sel_t;

  // datapath action
  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_ACCEPT   = 4'd1,
    ACT_CHECK    = 4'd2,
    ACT_SEED     = 4'd3,
    ACT_SCAN     = 4'd4,
    ACT_RESTART  = 4'd5,
    ACT_ANSWER   = 4'd6,
    ACT_CLR_INIT = 4'd7,
    ACT_CLR_STEP = 4'd8
  } act_t;

  // jump condition: taken jumps to target, else fall through
  typedef enum logic [3:0] {
    COND_NEVER     = 4'd0,
    COND_ALWAYS    = 4'd1,
    COND_NO_ITEM   = 4'd2,
    COND_NO_EDGE   = 4'd3,
    COND_NOT_LAST  = 4'd4,
    COND_SKIP      = 4'd5,
    COND_SCAN_MORE = 4'd6,
    COND_NO_CHANGE = 4'd7,
    COND_OUT_BUSY  = 4'd8
  } cond_t;

  typedef struct packed {
    rd_sel_t          rd_sel;
    wr_sel_t          wr_sel;
    act_t             act;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  // program steps
  localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] STEP_EDGE_RD  = 4'd1;
  localparam logic [PC_W-1:0] STEP_EDGE_WF  = 4'd2;
  localparam logic [PC_W-1:0] STEP_EDGE_WT  = 4'd3;
  localparam logic [PC_W-1:0] STEP_QUERY    = 4'd4;
  localparam logic [PC_W-1:0] STEP_DECIDE   = 4'd5;
  localparam logic [PC_W-1:0] STEP_SWEEP    = 4'd6;
  localparam logic [PC_W-1:0] STEP_DRAIN    = 4'd7;
  localparam logic [PC_W-1:0] STEP_RESTART  = 4'd8;
  localparam logic [PC_W-1:0] STEP_ANSWER   = 4'd9;
  localparam logic [PC_W-1:0] STEP_CLR_INIT = 4'd10;
  localparam logic [PC_W-1:0] STEP_CLR_ROW  = 4'd11;
  localparam logic [PC_W-1:0] STEP_WRAP     = 4'd12;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    begin
      w = '{RD_SCAN, WR_NONE, ACT_NONE, COND_ALWAYS, STEP_IDLE};
      unique case (pc)
        STEP_IDLE:     w = '{RD_SCAN, WR_NONE,    ACT_ACCEPT,   COND_NO_ITEM,   STEP_IDLE};
        STEP_EDGE_RD:  w = '{RD_FROM, WR_NONE,    ACT_CHECK,    COND_NO_EDGE,   STEP_QUERY};
        STEP_EDGE_WF:  w = '{RD_TO,   WR_FROM_OR, ACT_NONE,     COND_NEVER,     STEP_IDLE};
        STEP_EDGE_WT:  w = '{RD_SCAN, WR_TO_OR,   ACT_NONE,     COND_NEVER,     STEP_IDLE};
        STEP_QUERY:    w = '{RD_SCAN, WR_NONE,    ACT_NONE,     COND_NOT_LAST,  STEP_IDLE};
        STEP_DECIDE:   w = '{RD_SCAN, WR_NONE,    ACT_SEED,     COND_SKIP,      STEP_ANSWER};
        STEP_SWEEP:    w = '{RD_SCAN, WR_NONE,    ACT_SCAN,     COND_SCAN_MORE, STEP_SWEEP};
        STEP_DRAIN:    w = '{RD_SCAN, WR_NONE,    ACT_NONE,     COND_NO_CHANGE, STEP_ANSWER};
        STEP_RESTART:  w = '{RD_SCAN, WR_NONE,    ACT_RESTART,  COND_ALWAYS,    STEP_SWEEP};
        STEP_ANSWER:   w = '{RD_SCAN, WR_NONE,    ACT_ANSWER,   COND_OUT_BUSY,  STEP_ANSWER};
        STEP_CLR_INIT: w = '{RD_SCAN, WR_NONE,    ACT_CLR_INIT, COND_NEVER,     STEP_IDLE};
        STEP_CLR_ROW:  w = '{RD_SCAN, WR_CLEAR,   ACT_CLR_STEP, COND_SCAN_MORE, STEP_CLR_ROW};
        STEP_WRAP:     w = '{RD_SCAN, WR_NONE,    ACT_NONE,     COND_ALWAYS,    STEP_IDLE};
        default:       w = '{RD_SCAN, WR_NONE,    ACT_NONE,     COND_ALWAYS,    STEP_CLR_INIT};
      endcase
      return w;
    end
  endfunction

endpackage

// ===== rtl/core/grc_ram.sv =====
// grc_ram: generic single write port, single read port RAM with registered
// read data (read-before-write on an address clash). No dependencies.
module grc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/graph_reachability_check.sv =====
// graph_reachability_check: top level, microcode sequencer and datapath of
// the undirected reachability check. Depends on grc_pkg and grc_ram.
//
// Usage
//   Item channel (item_valid / item_stall): each item may carry one edge
//   (has_edge, edge_from, edge_to). The item with last_item set closes the
//   graph and carries the query (source_node, dest_node).
//   Result channel (result_valid / result_stall): one result per last item,
//   path_exists and bad_node; none for other items.
//   node_count is written through cfg_write / cfg_data while idle.
// Sequencing
//   An item with a stored edge passes through both edge write steps, which
//   any other item skips: the adjacency RAM has one port each way, so
//   an edge is two read-modify-writes.
//   A query sweeps the node rows once per round and repeats until a
//   round expands nothing (up to about NODES rounds).
//   An invalid or trivial query skips the sweep and goes straight to the
//   answer step. After each answer, and after reset, a clearing pass
//   writes every row to zero, and no item is accepted during it.
// Reset and stall
//   rst (synchronous) starts the clearing pass, drops result_valid and
//   sets node_count to 64. A stalled result holds in the output register;
//   the block waits in its answer step only if a new answer is ready then.
module graph_reachability_check #(
  parameter int NODES = grc_pkg::NODES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic [grc_pkg::COUNT_W-1:0]  cfg_data,
  // items
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         has_edge,
  input  logic [grc_pkg::NODE_W-1:0]   edge_from,
  input  logic [grc_pkg::NODE_W-1:0]   edge_to,
  input  logic                         last_item,
  input  logic [grc_pkg::NODE_W-1:0]   source_node,
  input  logic [grc_pkg::NODE_W-1:0]   dest_node,
  // results
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         path_exists,
  output logic                         bad_node
);

  localparam int IDX_W = $clog2(NODES);
  // wide enough for node_count and for NODES itself
  localparam int LIM_W = ($clog2(NODES + 1) > grc_pkg::COUNT_W) ?
                         $clog2(NODES + 1) : grc_pkg::COUNT_W;
  localparam logic [NODES-1:0] ONE_BIT = NODES'(1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NODES - 1);

  // ---------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------
  logic [grc_pkg::PC_W-1:0]   pc;
  logic [grc_pkg::PC_W-1:0]   pc_next;
  logic [grc_pkg::COUNT_W-1:0] node_count;

  logic                        item_has_edge;
  logic [grc_pkg::NODE_W-1:0]  item_from;
  logic [grc_pkg::NODE_W-1:0]  item_to;
  logic                        item_last;
  logic [grc_pkg::NODE_W-1:0]  item_src;
  logic [grc_pkg::NODE_W-1:0]  item_dst;

  logic                        range_err;   // bad edge seen in this graph
  logic [NODES-1:0]            visited;
  logic [NODES-1:0]            expanded;    // rows already ORed in
  logic [IDX_W-1:0]            scan;        // sweep / clear row pointer
  logic                        changed;     // a row was expanded this round
  logic                        rd_pend;     // RAM data is a row to merge

  // ---------------------------------------------------------------
  // control word
  // ---------------------------------------------------------------
  grc_pkg::ucode_t uw;
  assign uw = grc_pkg::ucode_rom(pc);

  // ---------------------------------------------------------------
  // node checks
  // ---------------------------------------------------------------
  logic [LIM_W-1:0] limit;
  logic             edge_ok;
  logic             query_bad;
  logic             same_node;
  logic             found;
  logic [IDX_W-1:0] from_idx;
  logic [IDX_W-1:0] to_idx;
  logic [IDX_W-1:0] src_idx;
  logic [IDX_W-1:0] dst_idx;

  // limit saturates at NODES
  assign limit = (LIM_W'(node_count) < LIM_W'(NODES)) ? LIM_W'(node_count) :
                 LIM_W'(NODES);
  assign edge_ok   = (LIM_W'(item_from) < limit) && (LIM_W'(item_to) < limit);
  assign query_bad = range_err || (LIM_W'(item_src) >= limit) ||
                     (LIM_W'(item_dst) >= limit);
  assign same_node = (item_src == item_dst);

  // indices are read before the limit check, but only a field that passed it steers a RAM write or the answer
  assign from_idx = IDX_W'(item_from);
  assign to_idx   = IDX_W'(item_to);
  assign src_idx  = IDX_W'(item_src);
  assign dst_idx  = IDX_W'(item_dst);

  assign found = !query_bad && (same_node || visited[dst_idx]);

  // ---------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------
  logic item_acc;
  logic out_busy;
  logic scan_last;
  logic expand_now;

  assign item_stall = (uw.act != grc_pkg::ACT_ACCEPT);
  assign item_acc   = item_valid && !item_stall;
  assign out_busy   = result_valid && result_stall;
  assign scan_last  = (scan == IDX_LAST);
  assign expand_now = (uw.act == grc_pkg::ACT_SCAN) && visited[scan] && !expanded[scan];

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  logic jump;

  always_comb begin
    unique case (uw.cond)
      grc_pkg::COND_NEVER:     jump = 1'b0;
      grc_pkg::COND_ALWAYS:    jump = 1'b1;
      grc_pkg::COND_NO_ITEM:   jump = !item_acc;
      grc_pkg::COND_NO_EDGE:   jump = !(item_has_edge && edge_ok);
      grc_pkg::COND_NOT_LAST:  jump = !item_last;
      grc_pkg::COND_SKIP:      jump = query_bad || same_node;
      grc_pkg::COND_SCAN_MORE: jump = !scan_last;
      grc_pkg::COND_NO_CHANGE: jump = !changed;
      grc_pkg::COND_OUT_BUSY:  jump = out_busy;
      default:                 jump = 1'b1;
    endcase
    pc_next = jump ? uw.target : pc + grc_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= grc_pkg::STEP_CLR_INIT;
    end else begin
      pc <= pc_next;
    end
  end

  // ---------------------------------------------------------------
  // adjacency matrix: one row per node
  // ---------------------------------------------------------------
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [NODES-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [NODES-1:0] ram_rdata;

  always_comb begin
    unique case (uw.rd_sel)
      grc_pkg::RD_FROM: ram_raddr = from_idx;
      grc_pkg::RD_TO:   ram_raddr = to_idx;
      default:          ram_raddr = scan;
    endcase
  end

  always_comb begin
    ram_we = 1'b1;
    unique case (uw.wr_sel)
      grc_pkg::WR_FROM_OR: begin
        ram_waddr = from_idx;
        ram_wdata = ram_rdata | (ONE_BIT << to_idx);
      end
      grc_pkg::WR_TO_OR: begin
        ram_waddr = to_idx;
        ram_wdata = ram_rdata | (ONE_BIT << from_idx);
      end
      grc_pkg::WR_CLEAR: begin
        ram_waddr = scan;
        ram_wdata = '0;
      end
      default: begin
        ram_we    = 1'b0;
        ram_waddr = scan;
        ram_wdata = '0;
      end
    endcase
  end

  grc_ram #(
    .WIDTH (NODES),
    .DEPTH (NODES)
  ) u_adj (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= grc_pkg::COUNT_RESET;
    end else if (cfg_write) begin
      node_count <= cfg_data;
    end
  end

  // ---------------------------------------------------------------
  // item capture
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (item_acc) begin
      item_has_edge <= has_edge;
      item_from     <= edge_from;
      item_to       <= edge_to;
      item_last     <= last_item;
      item_src      <= source_node;
      item_dst      <= dest_node;
    end
  end

  // ---------------------------------------------------------------
  // search datapath
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      range_err <= 1'b0;
      visited   <= '0;
      expanded  <= '0;
      scan      <= '0;
      changed   <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= expand_now;
      // row read last cycle lands now
      if (rd_pend) begin
        visited <= visited | ram_rdata;
      end
      unique case (uw.act)
        grc_pkg::ACT_CHECK: begin
          if (item_has_edge && !edge_ok) begin
            range_err <= 1'b1;
          end
        end
        grc_pkg::ACT_SEED: begin
          visited  <= ONE_BIT << src_idx;
          expanded <= '0;
          scan     <= '0;
          changed  <= 1'b0;
        end
        grc_pkg::ACT_SCAN: begin
          if (expand_now) begin
            expanded[scan] <= 1'b1;
            changed        <= 1'b1;
          end
          scan <= scan_last ? '0 : scan + IDX_W'(1);
        end
        grc_pkg::ACT_RESTART: begin
          scan    <= '0;
          changed <= 1'b0;
        end
        grc_pkg::ACT_CLR_INIT: begin
          range_err <= 1'b0;
          visited   <= '0;
          expanded  <= '0;
          scan      <= '0;
          changed   <= 1'b0;
        end
        grc_pkg::ACT_CLR_STEP: begin
          scan <= scan_last ? '0 : scan + IDX_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((uw.act == grc_pkg::ACT_ANSWER) && !out_busy) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uw.act == grc_pkg::ACT_ANSWER) && !out_busy) begin
      path_exists <= found;
      bad_node    <= query_bad;
    end
  end

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  a_result_from_answer: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(pc) == grc_pkg::STEP_ANSWER))
    else $error("result raised outside the answer step");

  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(path_exists && bad_node))
    else $error("path reported on a bad query");

  a_merge_after_sweep: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> ($past(pc) == grc_pkg::STEP_SWEEP))
    else $error("row merge without a sweep read");

  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= grc_pkg::STEP_WRAP)
    else $error("step counter beyond program");

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (pc == grc_pkg::STEP_CLR_ROW) |-> item_stall)
    else $error("item taken during clearing pass");

endmodule

// ===== test/tb_graph_reachability_check.sv =====
// tb_graph_reachability_check: self-checking testbench for the undirected
// graph reachability check. Depends on grc_pkg and graph_reachability_check;
// a mirror class predicts every answer and checks the result channel.

typedef struct packed {
  logic                       has_edge;
  logic [grc_pkg::NODE_W-1:0] edge_from;
  logic [grc_pkg::NODE_W-1:0] edge_to;
  logic                       last_item;
  logic [grc_pkg::NODE_W-1:0] source_node;
  logic [grc_pkg::NODE_W-1:0] dest_node;
} graph_item_t;

typedef struct packed {
  logic path_exists;
  logic bad_node;
} reach_answer_t;

// Mirror of the graph being built: adjacency matrix, range flag and
// node_count, plus the answers still owed by the block.
class graph_mirror;
  localparam int N = grc_pkg::NODES_DEFAULT;

  logic [N-1:0]                adj [N];
  bit                          range_err;
  logic [grc_pkg::COUNT_W-1:0] node_count;
  reach_answer_t               answers_due [$];
  int unsigned                 failures;

  function new();
    clear_graph();
    node_count = grc_pkg::COUNT_RESET;
    failures   = 0;
  endfunction

  function void clear_graph();
    foreach (adj[i]) adj[i] = '0;
    range_err = 1'b0;
  endfunction

  function void set_node_count(input logic [grc_pkg::COUNT_W-1:0] value);
    node_count = value;
  endfunction

  function int unsigned pending();
    return answers_due.size();
  endfunction

  // frontier expansion until nothing new turns up
  function bit reachable(input logic [grc_pkg::NODE_W-1:0] src,
                         input logic [grc_pkg::NODE_W-1:0] dst);
    logic [N-1:0] seen, front, grow;
    seen      = '0;
    seen[src] = 1'b1;
    front     = seen;
    while (front != '0) begin
      grow = '0;
      for (int v = 0; v < N; v++)
        if (front[v]) grow |= adj[v];
      grow  &= ~seen;
      seen  |= grow;
      front  = grow;
    end
    return seen[dst];
  endfunction

  function void note_item(input graph_item_t it);
    int unsigned   limit;
    reach_answer_t ans;
    limit = (node_count > N) ? N : node_count;
    if (it.has_edge) begin
      if (it.edge_from >= limit || it.edge_to >= limit) begin
        range_err = 1'b1;
      end else begin
        adj[it.edge_from][it.edge_to] = 1'b1;
        adj[it.edge_to][it.edge_from] = 1'b1;
      end
    end
    if (!it.last_item) return;
    ans.bad_node    = range_err || it.source_node >= limit || it.dest_node >= limit;
    ans.path_exists = 1'b0;
    if (!ans.bad_node)
      ans.path_exists = (it.source_node == it.dest_node) ||
                        reachable(it.source_node, it.dest_node);
    answers_due.insert(answers_due.size(), ans);
    clear_graph();
  endfunction

  function void check_answer(input logic path_exists, input logic bad_node);
    reach_answer_t want;
    if (answers_due.size() == 0) begin
      $error("result with no answer owed: path_exists %0b bad_node %0b",
             path_exists, bad_node);
      failures++;
      return;
    end
    want = answers_due.pop_front();
    if (path_exists !== want.path_exists) begin
      $error("path_exists: expected %0b, got %0b", want.path_exists, path_exists);
      failures++;
    end
    if (bad_node !== want.bad_node) begin
      $error("bad_node: expected %0b, got %0b", want.bad_node, bad_node);
      failures++;
    end
  endfunction
endclass

module tb_graph_reachability_check;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NODES       = grc_pkg::NODES_DEFAULT;
  // wait for the clearing pass after an answer, with some margin
  localparam int unsigned SETTLE      = NODES + 16;
  // long receiver hold-off: two worst-case graphs fit inside it, so the
  // block is sure to back up into its input
  localparam int unsigned HOLD_CYCLES = 3 * (NODES + 1) * (NODES + 2);
  // longest quiet stretch is the hold-off; several times over
  localparam int unsigned QUIET_LIMIT = 4 * HOLD_CYCLES;
  localparam int          PHASES      = 11;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_write;
  logic [grc_pkg::COUNT_W-1:0] cfg_data;
  logic                        item_valid;
  logic                        item_stall;
  logic                        has_edge;
  logic [grc_pkg::NODE_W-1:0]  edge_from;
  logic [grc_pkg::NODE_W-1:0]  edge_to;
  logic                        last_item;
  logic [grc_pkg::NODE_W-1:0]  source_node;
  logic [grc_pkg::NODE_W-1:0]  dest_node;
  logic                        result_valid;
  logic                        result_stall;
  logic                        path_exists;
  logic                        bad_node;

  graph_mirror mirror = new();

  bit          hold_results;   // raised by the stimulus, cleared by the sink
  bit          hold_done;
  int unsigned calm_left;      // items still to send back to back

  // node_count per random phase, extremes included, and items per phase
  int unsigned phase_count [PHASES] = '{64, 3, 127, 1, 20, 0, 64, 2, 64, 45, 64};
  int unsigned phase_items [PHASES] = '{200, 60, 120, 30, 100, 20, 150, 40, 120, 80, 130};

  graph_reachability_check DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .has_edge     (has_edge),
    .edge_from    (edge_from),
    .edge_to      (edge_to),
    .last_item    (last_item),
    .source_node  (source_node),
    .dest_node    (dest_node),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .path_exists  (path_exists),
    .bad_node     (bad_node)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Fully random item; callers overwrite the fields that matter.
  function automatic graph_item_t random_item();
    logic [31:0] r;
    r = $urandom();
    return r[$bits(graph_item_t)-1:0];
  endfunction

  function automatic graph_item_t pack_item(input bit h, input int unsigned f,
                                            input int unsigned t, input bit l,
                                            input int unsigned s, input int unsigned d);
    graph_item_t it;
    it.has_edge    = h;
    it.edge_from   = 6'(f);
    it.edge_to     = 6'(t);
    it.last_item   = l;
    it.source_node = 6'(s);
    it.dest_node   = 6'(d);
    return it;
  endfunction

  // Node from a small cluster of the valid range, with the odd stray value
  // anywhere in the field so that range errors turn up inside normal graphs.
  function automatic logic [grc_pkg::NODE_W-1:0] pool_node(input int unsigned base,
                                                          input int unsigned span,
                                                          input int unsigned lim);
    if ($urandom_range(0, 24) == 0) return 6'($urandom_range(0, 63));
    return 6'((base + $urandom_range(0, span - 1)) % lim);
  endfunction

  // Offer one item and hold it until the block takes it. Valid stays high
  // into the next call unless that call opens a gap.
  task automatic send_item(input graph_item_t it);
    int unsigned gap;
    if (calm_left != 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(10, 60);
    end
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    has_edge    <= it.has_edge;
    edge_from   <= it.edge_from;
    edge_to     <= it.edge_to;
    last_item   <= it.last_item;
    source_node <= it.source_node;
    dest_node   <= it.dest_node;
    do @(posedge clk); while (item_stall);
    mirror.note_item(it);
  endtask

  // Stop offering, wait for every owed answer, then let the clearing pass
  // finish so the block is truly idle.
  task automatic drain();
    item_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [grc_pkg::COUNT_W-1:0] value);
    drain();
    cfg_data  <= value;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    mirror.set_node_count(value);
  endtask

  // One whole graph closed by its query. Mostly small random clusters,
  // occasionally a long chain to force many search rounds. Filler items
  // without an edge are sprinkled in and counted like the rest.
  task automatic send_random_graph(input int unsigned limit, output int unsigned counted);
    int unsigned lim, base, span, n_edges, hi;
    bit          chain;
    graph_item_t it;
    counted = 0;
    lim     = (limit == 0 || limit > NODES) ? NODES : limit;
    base    = $urandom_range(0, lim - 1);
    chain   = (lim > 2) && ($urandom_range(0, 19) == 0);
    if (chain) begin
      span    = $urandom_range(3, lim);
      n_edges = span - 1;
    end else begin
      hi      = (lim < 10) ? lim : 10;
      span    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, lim) : $urandom_range(1, hi);
      n_edges = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
    end
    for (int unsigned e = 0; e < n_edges; e++) begin
      if ($urandom_range(0, 9) == 0) begin
        it           = random_item();
        it.has_edge  = 1'b0;
        it.last_item = 1'b0;
        send_item(it);
        counted++;
      end
      it           = random_item();
      it.has_edge  = 1'b1;
      it.last_item = 1'b0;
      if (chain) begin
        // either direction of the same link
        if ($urandom_range(0, 1) == 1) begin
          it.edge_from = 6'((base + e + 1) % lim);
          it.edge_to   = 6'((base + e) % lim);
        end else begin
          it.edge_from = 6'((base + e) % lim);
          it.edge_to   = 6'((base + e + 1) % lim);
        end
      end else begin
        it.edge_from = pool_node(base, span, lim);
        it.edge_to   = pool_node(base, span, lim);
      end
      send_item(it);
      counted++;
    end
    // the closing item, sometimes with an edge of its own
    it           = random_item();
    it.last_item = 1'b1;
    it.has_edge  = ($urandom_range(0, 2) == 0);
    if (it.has_edge) begin
      it.edge_from = pool_node(base, span, lim);
      it.edge_to   = pool_node(base, span, lim);
    end
    if (chain) begin
      it.source_node = 6'(base);
      it.dest_node   = 6'((base + span - 1) % lim);
    end else begin
      it.source_node = pool_node(base, span, lim);
      it.dest_node   = ($urandom_range(0, 6) == 0) ? it.source_node
                                                   : pool_node(base, span, lim);
    end
    send_item(it);
    counted++;
  endtask

  // Result monitor: every accepted result goes to the mirror.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) mirror.check_answer(path_exists, bad_node);
  end

  // Result sink: ready stretches broken by random stalls, and one long
  // hold-off on request so the block backs up into its item input.
  initial begin : result_sink
    int unsigned n;
    forever begin
      if (hold_results) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      n = pick_gap();
      if (n != 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any item or result moving ends the run.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent, got;
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_data    <= '0;
    item_valid  <= 1'b0;
    has_edge    <= 1'b0;
    edge_from   <= '0;
    edge_to     <= '0;
    last_item   <= 1'b0;
    source_node <= '0;
    dest_node   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    drain();   // reset also starts a clearing pass

    // Directed, node_count at its reset value of 64.
    send_item(pack_item(0, 0, 0, 1, 0, 0));      // same node, empty graph
    send_item(pack_item(0, 0, 0, 1, 0, 63));     // no edges: unreachable
    send_item(pack_item(1, 63, 0, 1, 0, 63));    // edge rides on the last item
    send_item(pack_item(1, 5, 5, 0, 0, 0));      // self loop only
    send_item(pack_item(0, 0, 0, 1, 5, 6));
    send_item(pack_item(1, 0, 1, 0, 0, 0));      // chain, reversed edge order
    send_item(pack_item(1, 2, 1, 0, 0, 0));
    send_item(pack_item(1, 2, 3, 0, 0, 0));
    send_item(pack_item(0, 63, 63, 0, 63, 63));  // filler, must be ignored
    send_item(pack_item(0, 0, 0, 1, 3, 0));
    send_item(pack_item(1, 10, 11, 0, 0, 0));    // two separate pieces
    send_item(pack_item(1, 20, 21, 0, 0, 0));
    send_item(pack_item(1, 11, 12, 1, 10, 21));

    // Directed, small node range: out-of-range edges and query nodes.
    write_node_count(7'd8);
    send_item(pack_item(1, 9, 1, 0, 0, 0));      // bad edge poisons the graph
    send_item(pack_item(0, 0, 0, 1, 1, 1));      // even for equal nodes
    send_item(pack_item(0, 0, 0, 1, 8, 8));
    send_item(pack_item(1, 7, 0, 0, 0, 0));      // highest valid node
    send_item(pack_item(0, 0, 0, 1, 0, 7));
    send_item(pack_item(0, 0, 0, 1, 1, 8));

    write_node_count(7'd0);                      // every node invalid
    send_item(pack_item(1, 0, 0, 1, 0, 0));

    write_node_count(7'd127);                    // saturates at NODES
    send_item(pack_item(1, 63, 62, 1, 62, 63));

    // Random phases.
    for (int p = 0; p < PHASES; p++) begin
      write_node_count(7'(phase_count[p]));
      sent = 0;
      while (sent < phase_items[p]) begin
        if (!hold_done && phase_count[p] == NODES && sent > 50) begin
          hold_results = 1'b1;
          hold_done    = 1'b1;
        end
        send_random_graph(phase_count[p], got);
        sent += got;
      end
    end

    drain();
    if (mirror.failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== graph_reachability_check.f =====
rtl/core/grc_pkg.sv
rtl/core/grc_ram.sv
rtl/core/graph_reachability_check.sv
test/tb_graph_reachability_check.sv
